>>> design/bounded_int_vector_engine_unit_assert.svh
// Assertion macros used by the bounded vector engine top level.
`ifndef BOUNDED_INT_VECTOR_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_INT_VECTOR_ENGINE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define BIVU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Condition that must never be true at a clock edge outside reset.
`define BIVU_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define BIVU_ASSERT(lbl, prop, msg)
`define BIVU_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> design/bivu_pkg.sv
// Types and constants of the bounded vector engine.
package bivu_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int OP_W          = 3;
   localparam int INDEX_W       = 16;
   localparam int WORD_W        = 32;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 5;

   localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
   localparam logic [OP_W-1:0] OP_POP   = 3'd1;
   localparam logic [OP_W-1:0] OP_GET   = 3'd2;
   localparam logic [OP_W-1:0] OP_ERASE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic        [OP_W-1:0]    op;
      logic        [INDEX_W-1:0] index;
      logic signed [WORD_W-1:0]  data;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]   value;
      logic        [STATUS_W-1:0] status;
      logic        [COUNT_W-1:0]  count;
   } rsp_type;

endpackage

>>> design/bivu_store.sv
// Word store: one write port and one read port with registered read data.
module bivu_store #(
   parameter int DEPTH = bivu_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [AW-1:0]                      wr_addr,
   input  logic signed [bivu_pkg::WORD_W-1:0] wr_data,
   input  logic [AW-1:0]                      rd_addr,
   output logic signed [bivu_pkg::WORD_W-1:0] rd_data
);

   logic signed [bivu_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic signed [bivu_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bounded_int_vector_engine_unit.sv
// Top level of the bounded vector engine: request decode, erase sequencer and result register.
//
//   Channel  Ports                                Direction  Carries
//   request  req_valid, req_ready, req_item       in         op, index, data
//   result   rsp_valid, rsp_ready, rsp_item       out        value, status, count
//
// Push, clear, unknown ops and every refused transaction give their result in the cycle after
// acceptance. Pop and get first make one read of the word store, with registered data. Erase
// moves each later word down in S_SHIFT, one word per cycle, through the single read and write
// ports of the store. Reset clears the count and the sequencer but not the store, as only
// positions below the count are ever used. A new request is taken only when the sequencer is
// idle and the result register is empty or being emptied in that cycle.
`include "bounded_int_vector_engine_unit_assert.svh"

module bounded_int_vector_engine_unit #(
   parameter int DEPTH = bivu_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bivu_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bivu_pkg::rsp_type rsp_item
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int IW    = bivu_pkg::INDEX_W;
   localparam int OW    = bivu_pkg::COUNT_W;
   localparam int WW    = bivu_pkg::WORD_W;

   // S_READ loads the result from the store; S_ERASE captures the erased word and
   // starts the shift if a later word remains; S_SHIFT moves one word down per cycle.
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_ERASE = 4'b0100,
      S_SHIFT = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [AW-1:0]             ptr_ff, ptr_in;
   logic signed [WW-1:0]      hold_ff, hold_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   bivu_pkg::rsp_type         rsp_item_ff, rsp_item_in;

   logic                      req_fire;
   logic                      in_range;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic signed [WW-1:0]      wr_data;
   logic [AW-1:0]             rd_addr;
   logic signed [WW-1:0]      rd_data;

   bivu_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A transaction is taken only when the sequencer is idle and the result register
   // will be free at the next edge, so every path below may load that register.
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign in_range  = req_item.index < IW'(count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = rd_data;
      rd_addr      = ptr_ff + AW'(2);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_item_in.value  = '0;
               rsp_item_in.status = bivu_pkg::ST_OK;
               rsp_item_in.count  = OW'(count_ff);
               case (req_item.op)
                  bivu_pkg::OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_item_in.status = bivu_pkg::ST_FULL;
                     end else begin
                        wr_en             = 1'b1;
                        wr_addr           = AW'(count_ff);
                        wr_data           = req_item.data;
                        count_in          = count_ff + CW'(1);
                        rsp_item_in.count = OW'(count_ff + CW'(1));
                     end
                  end
                  bivu_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_item_in.status = bivu_pkg::ST_RANGE;
                     end else begin
                        rd_addr  = AW'(count_ff - CW'(1));
                        count_in = count_ff - CW'(1);
                        state_in = S_READ;
                     end
                  end
                  bivu_pkg::OP_GET: begin
                     if (!in_range) begin
                        rsp_valid_in       = 1'b1;
                        rsp_item_in.status = bivu_pkg::ST_RANGE;
                     end else begin
                        rd_addr  = AW'(req_item.index);
                        state_in = S_READ;
                     end
                  end
                  bivu_pkg::OP_ERASE: begin
                     if (!in_range) begin
                        rsp_valid_in       = 1'b1;
                        rsp_item_in.status = bivu_pkg::ST_RANGE;
                     end else begin
                        rd_addr  = AW'(req_item.index);
                        ptr_in   = AW'(req_item.index);
                        count_in = count_ff - CW'(1);
                        state_in = S_ERASE;
                     end
                  end
                  bivu_pkg::OP_CLEAR: begin
                     rsp_valid_in      = 1'b1;
                     count_in          = '0;
                     rsp_item_in.count = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            // For a pop, the count was already lowered when the transaction was taken.
            rsp_valid_in       = 1'b1;
            rsp_item_in.value  = rd_data;
            rsp_item_in.status = bivu_pkg::ST_OK;
            rsp_item_in.count  = OW'(count_ff);
            state_in           = S_IDLE;
         end
         S_ERASE: begin
            // The erased word is at hand; fetch its successor if one remains.
            hold_in = rd_data;
            rd_addr = ptr_ff + AW'(1);
            if (CW'(ptr_ff) < count_ff) begin
               state_in = S_SHIFT;
            end else begin
               rsp_valid_in       = 1'b1;
               rsp_item_in.value  = rd_data;
               rsp_item_in.status = bivu_pkg::ST_OK;
               rsp_item_in.count  = OW'(count_ff);
               state_in           = S_IDLE;
            end
         end
         S_SHIFT: begin
            // Write the word read for ptr + 1 into ptr while fetching the one after.
            // Read and write addresses always differ by two, so no forwarding is needed.
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_data;
            rd_addr = ptr_ff + AW'(2);
            if (CW'(ptr_ff) + CW'(1) < count_ff) begin
               ptr_in = ptr_ff + AW'(1);
            end else begin
               rsp_valid_in       = 1'b1;
               rsp_item_in.value  = hold_ff;
               rsp_item_in.status = bivu_pkg::ST_OK;
               rsp_item_in.count  = OW'(count_ff);
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      hold_ff     <= hold_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `BIVU_ASSERT_NEVER(a_count_bound, count_ff > CW'(DEPTH), "count beyond capacity")
   `BIVU_ASSERT_NEVER(a_rsp_only_idle, rsp_valid_ff && (state_ff != S_IDLE), "result held while busy")
   `BIVU_ASSERT_NEVER(a_write_source, wr_en && !req_fire && (state_ff != S_SHIFT), "stray store write")
   `BIVU_ASSERT(a_read_completes, (state_ff == S_READ) |=> rsp_valid_ff, "read gave no result")

endmodule
